// ===== sv/bvp_pkg.sv =====
// shared constants and types for the bit vector with population count
`timescale 1ns / 1ps
package bvp_pkg;

  localparam int STORE_BYTES = 8192;
  localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int IDX_W       = 16;
  localparam int POS_W       = IDX_W - 3;
  localparam int CFG_W       = 14;
  localparam int POP_W       = 17;
  localparam int SIZE_W      = $clog2(STORE_BYTES + 1);
  localparam int LIM_W       = (CFG_W > SIZE_W) ? CFG_W : SIZE_W;
  localparam int LIM_W2      = (LIM_W > POS_W) ? LIM_W : POS_W;

  localparam logic [CFG_W-1:0]  VEC_BYTES_RST = CFG_W'(8192);
  localparam logic [LIM_W2-1:0] STORE_LIM     = LIM_W2'(STORE_BYTES);
  localparam logic [ADDR_W-1:0] LAST_ADDR     = ADDR_W'(STORE_BYTES - 1);

  typedef enum logic [1:0] {
    CMD_SET   = 2'd0,
    CMD_GET   = 2'd1,
    CMD_DEL   = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

endpackage

// ===== sv/bit_vector_with_popcount_top.sv =====
// bitmap store held in byte memory with a running count of set bits
//
// usage:
//   input channel (in_valid/in_ready) carries one request: a command (set, get,
//   delete, clear all) and a bit index. every request yields exactly one result
//   on the output channel (out_valid/out_ready): the read bit, the population
//   after the request and an out-of-range flag.
//   cfg_wr_en/cfg_wr_data write the number of bytes in use; write only when idle.
// timing:
//   set, get and delete each do the synchronous memory read when the request
//   is taken, then modify, write back and register the result in ST_MOD. the
//   next request is taken once the previous write-back is done, so the block
//   holds one request at a time.
//   clear all walks the memory one byte per cycle, then registers the result.
// reset:
//   rst_n is synchronous, active low. after reset the block runs the same
//   clearing pass with in_ready low; cfg writes are taken meanwhile.
// stalls:
//   the result sits in an output register; a new request is accepted while it
//   waits, and the write-back holds until out_ready frees the register.
`timescale 1ns / 1ps
module bit_vector_with_popcount_top (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_command,
  input  logic [bvp_pkg::IDX_W-1:0] in_bit_index,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_bit_value,
  output logic [bvp_pkg::POP_W-1:0] out_population,
  output logic                     out_out_of_range,
  input  logic                     cfg_wr_en,
  input  logic [bvp_pkg::CFG_W-1:0] cfg_wr_data
);

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_MOD,
    ST_CLR_DONE
  } state_t;

  state_t                          state_r;
  logic                            clr_cmd_r;
  logic [bvp_pkg::ADDR_W-1:0]      sweep_cnt_r;
  logic [bvp_pkg::CFG_W-1:0]       vec_bytes_r;
  logic [bvp_pkg::POP_W-1:0]       pop_r;
  logic [bvp_pkg::POP_W-1:0]       pop_nxt;
  logic                            out_valid_r;
  logic                            out_bit_r;
  logic [bvp_pkg::POP_W-1:0]       out_pop_r;
  logic                            out_oor_r;

  bvp_pkg::cmd_t                   cmd_r;
  logic [bvp_pkg::ADDR_W-1:0]      addr_r;
  logic [2:0]                      bitsel_r;
  logic                            oor_r;

  logic [7:0]                      mem [bvp_pkg::STORE_BYTES];
  logic [7:0]                      rd_data_r;

  bvp_pkg::cmd_t                   in_cmd;
  logic [bvp_pkg::POS_W-1:0]       in_pos;
  logic [bvp_pkg::LIM_W2-1:0]      cfg_ext;
  logic [bvp_pkg::LIM_W2-1:0]      limit;
  logic                            in_oor;
  logic                            accept;
  logic                            out_free;
  logic                            out_load;
  logic                            was_set;
  logic                            do_set;
  logic                            do_del;
  logic                            change;
  logic [7:0]                      mask;
  logic [7:0]                      new_byte;
  logic                            mem_we;
  logic [bvp_pkg::ADDR_W-1:0]      mem_waddr;
  logic [7:0]                      mem_wdata;

  assign in_cmd   = bvp_pkg::cmd_t'(in_command);
  assign in_pos   = in_bit_index[bvp_pkg::IDX_W-1:3];
  assign cfg_ext  = bvp_pkg::LIM_W2'(vec_bytes_r);
  assign limit    = (cfg_ext > bvp_pkg::STORE_LIM) ? bvp_pkg::STORE_LIM : cfg_ext;
  assign in_oor   = (in_cmd != bvp_pkg::CMD_CLEAR) &&
                    (bvp_pkg::LIM_W2'(in_pos) >= limit);

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign out_load = ((state_r == ST_MOD) || (state_r == ST_CLR_DONE)) && out_free;

  assign mask     = 8'(1) << bitsel_r;
  assign was_set  = (rd_data_r & mask) != 8'd0;
  assign do_set   = !oor_r && (cmd_r == bvp_pkg::CMD_SET) && !was_set;
  assign do_del   = !oor_r && (cmd_r == bvp_pkg::CMD_DEL) && was_set;
  assign change   = do_set || do_del;
  assign new_byte = do_set ? (rd_data_r | mask) : (rd_data_r & ~mask);

  always_comb begin
    pop_nxt = pop_r;
    if (do_set) begin
      pop_nxt = pop_r + bvp_pkg::POP_W'(1);
    end else if (do_del) begin
      pop_nxt = pop_r - bvp_pkg::POP_W'(1);
    end
  end

  assign mem_we    = (state_r == ST_SWEEP) ||
                     ((state_r == ST_MOD) && out_free && change);
  assign mem_waddr = (state_r == ST_SWEEP) ? sweep_cnt_r : addr_r;
  assign mem_wdata = (state_r == ST_SWEEP) ? 8'd0 : new_byte;

  // byte memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (accept) begin
      rd_data_r <= mem[bvp_pkg::ADDR_W'(in_pos)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      clr_cmd_r   <= 1'b0;
      sweep_cnt_r <= '0;
      vec_bytes_r <= bvp_pkg::VEC_BYTES_RST;
      pop_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        vec_bytes_r <= cfg_wr_data;
      end
      if (out_ready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_SWEEP: begin
          if (sweep_cnt_r == bvp_pkg::LAST_ADDR) begin
            sweep_cnt_r <= '0;
            state_r     <= clr_cmd_r ? ST_CLR_DONE : ST_IDLE;
          end else begin
            sweep_cnt_r <= sweep_cnt_r + bvp_pkg::ADDR_W'(1);
          end
        end
        ST_IDLE: begin
          if (accept) begin
            cmd_r    <= in_cmd;
            addr_r   <= bvp_pkg::ADDR_W'(in_pos);
            bitsel_r <= in_bit_index[2:0];
            oor_r    <= in_oor;
            if (in_cmd == bvp_pkg::CMD_CLEAR) begin
              clr_cmd_r   <= 1'b1;
              sweep_cnt_r <= '0;
              pop_r       <= '0;
              state_r     <= ST_SWEEP;
            end else begin
              state_r <= ST_MOD;
            end
          end
        end
        ST_MOD: begin
          if (out_free) begin
            pop_r       <= pop_nxt;
            out_valid_r <= 1'b1;
            out_bit_r   <= !oor_r && (cmd_r == bvp_pkg::CMD_GET) && was_set;
            out_pop_r   <= pop_nxt;
            out_oor_r   <= oor_r;
            state_r     <= ST_IDLE;
          end
        end
        ST_CLR_DONE: begin
          if (out_free) begin
            clr_cmd_r   <= 1'b0;
            out_valid_r <= 1'b1;
            out_bit_r   <= 1'b0;
            out_pop_r   <= '0;
            out_oor_r   <= 1'b0;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_bit_value    = out_bit_r;
  assign out_population   = out_pop_r;
  assign out_out_of_range = out_oor_r;

endmodule

// ===== sv/bvp_checker.sv =====
// port-level checks for the bit vector with population count
`timescale 1ns / 1ps
module bvp_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic                      out_bit_value,
  input  logic [bvp_pkg::POP_W-1:0] out_population,
  input  logic                      out_out_of_range
);

  // one request in flight: no back-to-back accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while previous one in flight");

  // out-of-range results never report a set bit
  a_oor_no_bit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_range |-> !out_bit_value)
    else $error("out-of-range result with bit value set");

  // reset drops the result channel and blocks requests during the clearing pass
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("activity right after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_population) &&
      $stable(out_bit_value) && $stable(out_out_of_range))
    else $error("stalled result changed");

endmodule

bind bit_vector_with_popcount_top bvp_checker u_bvp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_bit_value    (out_bit_value),
  .out_population   (out_population),
  .out_out_of_range (out_out_of_range)
);

// ===== dv/tb_bit_vector_with_popcount_top.sv =====
// testbench for the bit vector with population count: directed and random requests, scoreboard
`timescale 1ns / 1ps
module tb_bit_vector_with_popcount_top;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int CLEAR_BUDGET = 5;

  typedef struct packed {
    logic                      bit_value;
    logic [bvp_pkg::POP_W-1:0] population;
    logic                      out_of_range;
  } reply_t;

  logic                      clk;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [1:0]                in_command = bvp_pkg::CMD_GET;
  logic [bvp_pkg::IDX_W-1:0] in_bit_index = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic                      out_bit_value;
  logic [bvp_pkg::POP_W-1:0] out_population;
  logic                      out_out_of_range;
  logic                      cfg_wr_en = 1'b0;
  logic [bvp_pkg::CFG_W-1:0] cfg_wr_data = '0;

  // predictor state
  logic [7:0]                bitmap_bytes [bvp_pkg::STORE_BYTES];
  logic [bvp_pkg::POP_W-1:0] bits_set_total;
  logic [bvp_pkg::CFG_W-1:0] size_reg;
  reply_t                    predicted_q [$];

  reply_t got_reply;
  reply_t want_reply;
  int     mismatch_count = 0;
  int     request_count = 0;
  int     clear_count = 0;
  int     oor_seen = 0;
  int     size_writes = 0;
  int     clears_left = CLEAR_BUDGET;
  int     cycle_count = 0;
  int     stall_left = 0;
  int     stall_pick;
  int     hot_base = 0;
  bit     calm_mode = 1'b0;

  bit_vector_with_popcount_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_bit_index     (in_bit_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_bit_value    (out_bit_value),
    .out_population   (out_population),
    .out_out_of_range (out_out_of_range),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int size_limit();
    return (size_reg > bvp_pkg::STORE_BYTES) ? bvp_pkg::STORE_BYTES : int'(size_reg);
  endfunction

  function automatic void apply_request(input bvp_pkg::cmd_t cmd,
                                        input logic [bvp_pkg::IDX_W-1:0] idx);
    reply_t     rep;
    int         byte_at;
    logic [7:0] mask;
    rep = '0;
    byte_at = int'(idx >> 3);
    mask = 8'b1 << idx[2:0];
    if (cmd == bvp_pkg::CMD_CLEAR) begin
      foreach (bitmap_bytes[i]) bitmap_bytes[i] = '0;
      bits_set_total = '0;
      clear_count++;
    end else if (byte_at >= size_limit()) begin
      rep.out_of_range = 1'b1;
    end else begin
      case (cmd)
        bvp_pkg::CMD_GET: begin
          rep.bit_value = |(bitmap_bytes[byte_at] & mask);
        end
        bvp_pkg::CMD_SET: begin
          if (!(|(bitmap_bytes[byte_at] & mask))) begin
            bitmap_bytes[byte_at] = bitmap_bytes[byte_at] | mask;
            bits_set_total = bits_set_total + 1'b1;
          end
        end
        bvp_pkg::CMD_DEL: begin
          if (|(bitmap_bytes[byte_at] & mask)) begin
            bitmap_bytes[byte_at] = bitmap_bytes[byte_at] & ~mask;
            bits_set_total = bits_set_total - 1'b1;
          end
        end
        default: ;
      endcase
    end
    rep.population = bits_set_total;
    predicted_q.push_back(rep);
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [bvp_pkg::IDX_W-1:0] pick_index();
    int lim;
    int span;
    int r;
    lim = size_limit();
    r = $urandom_range(0, 99);
    if (lim == 0 || r >= 85) return bvp_pkg::IDX_W'($urandom);
    if (r >= 70) return bvp_pkg::IDX_W'(lim * 8 - 16 + $urandom_range(0, 31));
    span = (lim * 8 < 512) ? lim * 8 : 512;
    return bvp_pkg::IDX_W'(hot_base + $urandom_range(0, span - 1));
  endfunction

  function automatic bvp_pkg::cmd_t pick_command();
    int r;
    r = $urandom_range(0, 199);
    if (r < 70) return bvp_pkg::CMD_SET;
    if (r < 130) return bvp_pkg::CMD_GET;
    if (r >= 198 && clears_left > 0) begin
      clears_left--;
      return bvp_pkg::CMD_CLEAR;
    end
    return bvp_pkg::CMD_DEL;
  endfunction

  task automatic send_request(input bvp_pkg::cmd_t cmd,
                              input logic [bvp_pkg::IDX_W-1:0] idx);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_command   <= cmd;
    in_bit_index <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_request(cmd, idx);
    request_count++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (predicted_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_size(input logic [bvp_pkg::CFG_W-1:0] value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    size_reg = value;
    size_writes++;
  endtask

  task automatic test_basic_commands();
    send_request(bvp_pkg::CMD_GET, 16'd0);
    send_request(bvp_pkg::CMD_SET, 16'd0);
    send_request(bvp_pkg::CMD_SET, 16'd0);
    send_request(bvp_pkg::CMD_GET, 16'd0);
    send_request(bvp_pkg::CMD_SET, 16'hFFFF);
    send_request(bvp_pkg::CMD_GET, 16'hFFFF);
    send_request(bvp_pkg::CMD_DEL, 16'hFFFF);
    send_request(bvp_pkg::CMD_DEL, 16'hFFFF);
    send_request(bvp_pkg::CMD_SET, 16'd7);
    send_request(bvp_pkg::CMD_SET, 16'd8);
    send_request(bvp_pkg::CMD_CLEAR, 16'hFFFF);
    send_request(bvp_pkg::CMD_GET, 16'd0);
    wait_drained();
  endtask

  task automatic test_size_bounds();
    write_size(bvp_pkg::CFG_W'(1));
    send_request(bvp_pkg::CMD_SET, 16'd7);
    send_request(bvp_pkg::CMD_SET, 16'd8);
    send_request(bvp_pkg::CMD_GET, 16'd8);
    send_request(bvp_pkg::CMD_DEL, 16'd7);
    wait_drained();
    write_size(bvp_pkg::CFG_W'(0));
    send_request(bvp_pkg::CMD_SET, 16'd0);
    send_request(bvp_pkg::CMD_GET, 16'd0);
    wait_drained();
    // above the store size acts as the full store
    write_size({bvp_pkg::CFG_W{1'b1}});
    send_request(bvp_pkg::CMD_SET, 16'hFFFF);
    send_request(bvp_pkg::CMD_SET, 16'hFFFE);
    wait_drained();
    // shrink below bits already set: they stay counted
    write_size(bvp_pkg::CFG_W'(8191));
    send_request(bvp_pkg::CMD_GET, 16'hFFFF);
    send_request(bvp_pkg::CMD_DEL, 16'hFFFF);
    send_request(bvp_pkg::CMD_GET, 16'hFFF7);
    wait_drained();
  endtask

  task automatic run_phase(input logic [bvp_pkg::CFG_W-1:0] size, input int count,
                           input bit calm);
    int lim;
    write_size(size);
    lim = size_limit();
    hot_base = (lim * 8 > 512) ? $urandom_range(0, lim * 8 - 512) : 0;
    calm_mode = calm;
    repeat (count) send_request(pick_command(), pick_index());
    wait_drained();
    calm_mode = 1'b0;
  endtask

  task automatic test_random_traffic();
    run_phase(bvp_pkg::CFG_W'(bvp_pkg::STORE_BYTES), 105, 1'b0);
    run_phase({bvp_pkg::CFG_W{1'b1}}, 105, 1'b1);
    run_phase(bvp_pkg::CFG_W'(1), 105, 1'b0);
    run_phase(bvp_pkg::CFG_W'($urandom_range(2, 64)), 105, 1'b0);
    run_phase(bvp_pkg::CFG_W'($urandom_range(65, bvp_pkg::STORE_BYTES - 1)), 105, 1'b0);
    run_phase(bvp_pkg::CFG_W'(0), 40, 1'b0);
    run_phase(bvp_pkg::CFG_W'(bvp_pkg::STORE_BYTES), 60, 1'b0);
  endtask

  // result side backpressure
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (calm_mode) begin
      out_ready <= 1'b1;
    end else begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 70) begin
        out_ready <= 1'b1;
      end else if (stall_pick < 95) begin
        out_ready  <= 1'b0;
        stall_left <= $urandom_range(0, 2);
      end else begin
        out_ready  <= 1'b0;
        stall_left <= $urandom_range(10, 40);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got_reply = '{out_bit_value, out_population, out_out_of_range};
      if (predicted_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: bit %0b pop %0d oor %0b",
                   got_reply.bit_value, got_reply.population, got_reply.out_of_range);
      end else begin
        want_reply = predicted_q.pop_front();
        if (want_reply.out_of_range) oor_seen++;
        if (got_reply !== want_reply) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"mismatch at %0t: expected bit %0b pop %0d oor %0b, ",
                      "got bit %0b pop %0d oor %0b"},
                     $realtime, want_reply.bit_value, want_reply.population,
                     want_reply.out_of_range, got_reply.bit_value, got_reply.population,
                     got_reply.out_of_range);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("bit_vector_with_popcount_top test failed");
      $finish;
    end
  end

  initial begin
    foreach (bitmap_bytes[i]) bitmap_bytes[i] = '0;
    bits_set_total = '0;
    size_reg = bvp_pkg::VEC_BYTES_RST;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_basic_commands();
    test_size_bounds();
    test_random_traffic();
    wait_drained();
    repeat (10) @(posedge clk);
    $display("covered %0d requests, %0d clears, %0d out-of-range results, %0d size writes",
             request_count, clear_count, oor_seen, size_writes);
    $display("final population %0d, mismatches %0d", bits_set_total, mismatch_count);
    if (mismatch_count == 0 && predicted_q.size() == 0) begin
      $display("bit_vector_with_popcount_top test passed");
    end else begin
      $display("bit_vector_with_popcount_top test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/bvp_pkg.sv
sv/bit_vector_with_popcount_top.sv
sv/bvp_checker.sv
dv/tb_bit_vector_with_popcount_top.sv
